[design/list_min_max_mode_stats_defines.svh]
// Assertion macros for the list statistics block.
`ifndef LIST_MIN_MAX_MODE_STATS_DEFINES_SVH
`define LIST_MIN_MAX_MODE_STATS_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define LMMS_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define LMMS_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[design/lmms_pkg.sv]
package lmms_pkg;

	localparam int LIST_DEPTH_DEF = 32;
	localparam int VAL_W          = 32;
	localparam int OCC_W          = 6;
	localparam int KIND_W         = 2;

	typedef enum logic [KIND_W-1:0] {
		KIND_MIN    = 2'd0,
		KIND_MAX    = 2'd1,
		KIND_UNIQUE = 2'd2,
		KIND_MODE   = 2'd3
	} kind_t;

	typedef enum logic [3:0] {
		ST_LOAD,
		ST_KEY_RD,
		ST_KEY_LATCH,
		ST_COUNT,
		ST_MM_COUNT,
		ST_EMIT_MIN,
		ST_EMIT_MAX,
		ST_UNIQ_RD,
		ST_UNIQ_CHK,
		ST_MODE_RD,
		ST_MODE_CHK
	} state_t;

	typedef struct packed {
		logic lt_lo;
		logic gt_hi;
		logic eq_lo;
		logic eq_hi;
	} cmp_flags_t;

endpackage

[design/lmms_if.sv]
interface lmms_in_if;
	logic                           valid;
	logic                           ready;
	logic [lmms_pkg::VAL_W-1:0]     sample;
	logic                           end_of_list;

	modport source (output valid, output sample, output end_of_list, input ready);
	modport sink   (input valid, input sample, input end_of_list, output ready);
endinterface

interface lmms_out_if;
	logic                           valid;
	logic                           ready;
	logic [lmms_pkg::KIND_W-1:0]    kind;
	logic [lmms_pkg::VAL_W-1:0]     result_value;
	logic [lmms_pkg::OCC_W-1:0]     occurrences;
	logic                           overflowed;
	logic                           final_result;

	modport source (output valid, output kind, output result_value, output occurrences,
		output overflowed, output final_result, input ready);
	modport sink   (input valid, input kind, input result_value, input occurrences,
		input overflowed, input final_result, output ready);
endinterface

[design/lmms_store.sv]
module lmms_store #(
	parameter int DEPTH = lmms_pkg::LIST_DEPTH_DEF,
	parameter int AW    = $clog2(DEPTH),
	parameter int CW    = $clog2(DEPTH + 1)
) (
	input  logic                       clk,
	input  logic                       val_we,
	input  logic [AW-1:0]              val_waddr,
	input  logic [lmms_pkg::VAL_W-1:0] val_wdata,
	input  logic                       cnt_we,
	input  logic [AW-1:0]              cnt_waddr,
	input  logic [CW-1:0]              cnt_wdata,
	input  logic                       rd_en,
	input  logic [AW-1:0]              rd_addr,
	output logic [lmms_pkg::VAL_W-1:0] rd_value,
	output logic [CW-1:0]              rd_count
);

	logic [lmms_pkg::VAL_W-1:0] val_mem [DEPTH];
	logic [CW-1:0]              cnt_mem [DEPTH];

	always_ff @(posedge clk) begin
		if (val_we) begin
			val_mem[val_waddr] <= val_wdata;
		end
		if (rd_en) begin
			rd_value <= val_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cnt_we) begin
			cnt_mem[cnt_waddr] <= cnt_wdata;
		end
		if (rd_en) begin
			rd_count <= cnt_mem[rd_addr];
		end
	end

endmodule

[design/lmms_cmp.sv]
module lmms_cmp (
	input  logic [lmms_pkg::VAL_W-1:0] a,
	input  logic [lmms_pkg::VAL_W-1:0] lo,
	input  logic [lmms_pkg::VAL_W-1:0] hi,
	output lmms_pkg::cmp_flags_t       flags
);

	always_comb begin
		flags.lt_lo = $signed(a) < $signed(lo);
		flags.gt_hi = $signed(a) > $signed(hi);
		flags.eq_lo = a == lo;
		flags.eq_hi = a == hi;
	end

endmodule

[design/list_min_max_mode_stats.sv]
// List statistics over signed Q16.16 values. Values are taken one beat per cycle
// until a beat with end_of_list; min and max track on the fly and the first
// LIST_DEPTH values are stored (later ones set the overflow flag). After the last
// beat the input is held off while one shared comparator walks the store: for each
// of the n stored values a full scan of the store, one more scan to count min and
// max, then a pass for uniques and, when some value repeats, a pass for modes
// (both passes wait on output stalls). The value store has a single read port.
// Results come out as minimum, maximum, uniques in input order, then modes at
// their first position; the last result carries final_result.
module list_min_max_mode_stats #(
	parameter int LIST_DEPTH = lmms_pkg::LIST_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	lmms_in_if.sink           samples,
	lmms_out_if.source        results
);

	localparam int AW = $clog2(LIST_DEPTH);
	localparam int CW = $clog2(LIST_DEPTH + 1);
	localparam int TW = $clog2(LIST_DEPTH + 3);

	lmms_pkg::state_t           state_q, state_d;
	lmms_pkg::cmp_flags_t       flags;

	logic [CW-1:0]              fill_q, i_q, j_q, ridx_s1, cnt_q;
	logic [CW-1:0]              maxc_q, nmode_q, nuniq_q, cmin_q, cmax_q;
	logic [lmms_pkg::VAL_W-1:0] min_q, max_q, key_q;
	logic                       ovf_q, first_q, rvld_s1;
	logic [TW-1:0]              emit_q, total;

	logic                       ovld_q, okind_fin_q, oovf_q;
	logic [lmms_pkg::KIND_W-1:0] okind_q;
	logic [lmms_pkg::VAL_W-1:0] oval_q;
	logic [lmms_pkg::OCC_W-1:0] oocc_q;

	logic                       acc, slot_free, scan_state, scan_issue, scan_done, last_i;
	logic                       hit, first_nx, emit_hit, advance, list_end, load_out;
	logic [CW-1:0]              cnt_nx;
	logic                       rd_en;
	logic [AW-1:0]              rd_addr;
	logic [lmms_pkg::VAL_W-1:0] rd_value, cmp_a, cmp_lo;
	logic [CW-1:0]              rd_count;
	lmms_pkg::kind_t            ld_kind;
	logic [lmms_pkg::VAL_W-1:0] ld_val;
	logic [CW-1:0]              ld_occ;
	logic                       val_we, cnt_we;
	logic                       mode_pass;

	lmms_store #(.DEPTH(LIST_DEPTH), .AW(AW), .CW(CW)) u_store (
		.clk       (clk),
		.val_we    (val_we),
		.val_waddr (fill_q[AW-1:0]),
		.val_wdata (samples.sample),
		.cnt_we    (cnt_we),
		.cnt_waddr (i_q[AW-1:0]),
		.cnt_wdata (first_nx ? cnt_nx : '0),
		.rd_en     (rd_en),
		.rd_addr   (rd_addr),
		.rd_value  (rd_value),
		.rd_count  (rd_count)
	);

	assign cmp_a  = (state_q == lmms_pkg::ST_LOAD) ? samples.sample : rd_value;
	assign cmp_lo = (state_q == lmms_pkg::ST_COUNT) ? key_q : min_q;

	lmms_cmp u_cmp (
		.a     (cmp_a),
		.lo    (cmp_lo),
		.hi    (max_q),
		.flags (flags)
	);

	assign samples.ready = state_q == lmms_pkg::ST_LOAD;
	assign acc        = samples.valid && samples.ready;
	assign val_we     = acc && (fill_q < CW'(LIST_DEPTH));
	assign slot_free  = !ovld_q || results.ready;
	assign scan_state = (state_q == lmms_pkg::ST_COUNT) || (state_q == lmms_pkg::ST_MM_COUNT);
	assign scan_issue = scan_state && (j_q < fill_q);
	assign scan_done  = scan_state && rvld_s1 && (ridx_s1 == fill_q - CW'(1));
	assign last_i     = i_q == fill_q - CW'(1);
	assign hit        = rvld_s1 && flags.eq_lo;
	assign cnt_nx     = cnt_q + CW'(hit);
	assign first_nx   = first_q && !(hit && (ridx_s1 < i_q));
	assign cnt_we     = (state_q == lmms_pkg::ST_COUNT) && scan_done;
	assign mode_pass  = maxc_q > CW'(1);
	assign emit_hit   = (state_q == lmms_pkg::ST_UNIQ_CHK) ? (rd_count == CW'(1))
	                                                       : (rd_count == maxc_q);
	assign advance    = ((state_q == lmms_pkg::ST_UNIQ_CHK) ||
	                     (state_q == lmms_pkg::ST_MODE_CHK)) && (!emit_hit || slot_free);
	assign list_end   = advance && last_i &&
	                    ((state_q == lmms_pkg::ST_MODE_CHK) || !mode_pass);
	assign total      = TW'(2) + TW'(nuniq_q) + (mode_pass ? TW'(nmode_q) : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lmms_pkg::ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		rd_en    = 1'b0;
		rd_addr  = i_q[AW-1:0];
		load_out = 1'b0;
		ld_kind  = lmms_pkg::KIND_MIN;
		ld_val   = min_q;
		ld_occ   = cmin_q;
		case (state_q)
			lmms_pkg::ST_LOAD: begin
				if (acc && samples.end_of_list) begin
					state_d = lmms_pkg::ST_KEY_RD;
				end
			end
			lmms_pkg::ST_KEY_RD: begin
				rd_en   = 1'b1;
				state_d = lmms_pkg::ST_KEY_LATCH;
			end
			lmms_pkg::ST_KEY_LATCH: begin
				state_d = lmms_pkg::ST_COUNT;
			end
			lmms_pkg::ST_COUNT: begin
				rd_en   = scan_issue;
				rd_addr = j_q[AW-1:0];
				if (scan_done) begin
					state_d = last_i ? lmms_pkg::ST_MM_COUNT : lmms_pkg::ST_KEY_RD;
				end
			end
			lmms_pkg::ST_MM_COUNT: begin
				rd_en   = scan_issue;
				rd_addr = j_q[AW-1:0];
				if (scan_done) begin
					state_d = lmms_pkg::ST_EMIT_MIN;
				end
			end
			lmms_pkg::ST_EMIT_MIN: begin
				load_out = slot_free;
				if (slot_free) begin
					state_d = lmms_pkg::ST_EMIT_MAX;
				end
			end
			lmms_pkg::ST_EMIT_MAX: begin
				ld_kind  = lmms_pkg::KIND_MAX;
				ld_val   = max_q;
				ld_occ   = cmax_q;
				load_out = slot_free;
				if (slot_free) begin
					state_d = lmms_pkg::ST_UNIQ_RD;
				end
			end
			lmms_pkg::ST_UNIQ_RD: begin
				rd_en   = 1'b1;
				state_d = lmms_pkg::ST_UNIQ_CHK;
			end
			lmms_pkg::ST_UNIQ_CHK: begin
				ld_kind  = lmms_pkg::KIND_UNIQUE;
				ld_val   = rd_value;
				ld_occ   = rd_count;
				load_out = emit_hit && slot_free;
				if (advance) begin
					if (!last_i) begin
						state_d = lmms_pkg::ST_UNIQ_RD;
					end else if (mode_pass) begin
						state_d = lmms_pkg::ST_MODE_RD;
					end else begin
						state_d = lmms_pkg::ST_LOAD;
					end
				end
			end
			lmms_pkg::ST_MODE_RD: begin
				rd_en   = 1'b1;
				state_d = lmms_pkg::ST_MODE_CHK;
			end
			lmms_pkg::ST_MODE_CHK: begin
				ld_kind  = lmms_pkg::KIND_MODE;
				ld_val   = rd_value;
				ld_occ   = maxc_q;
				load_out = emit_hit && slot_free;
				if (advance) begin
					state_d = last_i ? lmms_pkg::ST_LOAD : lmms_pkg::ST_MODE_RD;
				end
			end
			default: begin
				state_d = lmms_pkg::ST_LOAD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q  <= '0;
			ovf_q   <= 1'b0;
			min_q   <= '0;
			max_q   <= '0;
			i_q     <= '0;
			j_q     <= '0;
			rvld_s1 <= 1'b0;
			ridx_s1 <= '0;
			cnt_q   <= '0;
			first_q <= 1'b0;
			key_q   <= '0;
			maxc_q  <= '0;
			nmode_q <= '0;
			nuniq_q <= '0;
			cmin_q  <= '0;
			cmax_q  <= '0;
			emit_q  <= '0;
		end else begin
			rvld_s1 <= scan_issue;
			ridx_s1 <= j_q;
			if (scan_issue) begin
				j_q <= j_q + CW'(1);
			end

			if (acc) begin
				if (fill_q == '0) begin
					min_q <= samples.sample;
					max_q <= samples.sample;
				end else begin
					if (flags.lt_lo) min_q <= samples.sample;
					if (flags.gt_hi) max_q <= samples.sample;
				end
				if (val_we) begin
					fill_q <= fill_q + CW'(1);
				end else begin
					ovf_q <= 1'b1;
				end
				if (samples.end_of_list) begin
					i_q     <= '0;
					maxc_q  <= '0;
					nmode_q <= '0;
					nuniq_q <= '0;
				end
			end

			if (state_q == lmms_pkg::ST_KEY_LATCH) begin
				key_q   <= rd_value;
				j_q     <= '0;
				cnt_q   <= '0;
				first_q <= 1'b1;
			end

			if (state_q == lmms_pkg::ST_COUNT) begin
				cnt_q   <= cnt_nx;
				first_q <= first_nx;
				if (scan_done) begin
					i_q <= i_q + CW'(1);
					if (first_nx) begin
						if (cnt_nx == CW'(1)) nuniq_q <= nuniq_q + CW'(1);
						if (cnt_nx > maxc_q) begin
							maxc_q  <= cnt_nx;
							nmode_q <= CW'(1);
						end else if (cnt_nx == maxc_q) begin
							nmode_q <= nmode_q + CW'(1);
						end
					end
					if (last_i) begin
						j_q    <= '0;
						cmin_q <= '0;
						cmax_q <= '0;
					end
				end
			end

			if ((state_q == lmms_pkg::ST_MM_COUNT) && rvld_s1) begin
				if (flags.eq_lo) cmin_q <= cmin_q + CW'(1);
				if (flags.eq_hi) cmax_q <= cmax_q + CW'(1);
			end

			if ((state_q == lmms_pkg::ST_EMIT_MAX) && slot_free) begin
				i_q <= '0;
			end
			if (advance) begin
				i_q <= last_i ? '0 : i_q + CW'(1);
			end

			if (list_end) begin
				emit_q <= '0;
			end else if (load_out) begin
				emit_q <= emit_q + TW'(1);
			end

			if (list_end) begin
				fill_q <= '0;
				ovf_q  <= 1'b0;
				min_q  <= '0;
				max_q  <= '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovld_q <= 1'b0;
		end else if (load_out) begin
			ovld_q <= 1'b1;
		end else if (results.ready) begin
			ovld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			okind_q     <= ld_kind;
			oval_q      <= ld_val;
			oocc_q      <= lmms_pkg::OCC_W'(ld_occ);
			oovf_q      <= ovf_q;
			okind_fin_q <= emit_q == total - TW'(1);
		end
	end

	assign results.valid        = ovld_q;
	assign results.kind         = okind_q;
	assign results.result_value = oval_q;
	assign results.occurrences  = oocc_q;
	assign results.overflowed   = oovf_q;
	assign results.final_result = okind_fin_q;

endmodule

[design/lmms_checker.sv]
`include "list_min_max_mode_stats_defines.svh"

module lmms_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic                          in_end_of_list,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [lmms_pkg::KIND_W-1:0]   out_kind,
	input logic [lmms_pkg::OCC_W-1:0]    out_occurrences,
	input logic                          out_final_result
);

	// held beat must stay offered
	`LMMS_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid, "result beat dropped")
	// end of list starts the counting phase
	`LMMS_ASSERT_NXT(a_eol_busy, in_valid && in_ready && in_end_of_list, !in_ready, "input open after last beat")
	// maximum always follows the minimum
	`LMMS_ASSERT_IMP(a_min_not_final, out_valid && out_kind == lmms_pkg::KIND_MIN, !out_final_result, "minimum beat marked final")
	// a unique value occurs once
	`LMMS_ASSERT_IMP(a_unique_once, out_valid && out_kind == lmms_pkg::KIND_UNIQUE, out_occurrences == lmms_pkg::OCC_W'(1), "unique beat count not one")

endmodule

bind list_min_max_mode_stats lmms_checker u_lmms_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.in_valid         (samples.valid),
	.in_ready         (samples.ready),
	.in_end_of_list   (samples.end_of_list),
	.out_valid        (results.valid),
	.out_ready        (results.ready),
	.out_kind         (results.kind),
	.out_occurrences  (results.occurrences),
	.out_final_result (results.final_result)
);
